@@ rtl/fapl_pkg.sv @@
// ----------------------------------------------------------------------------
// fapl_pkg
// shared types, codes and widths of the frame address pair learning table
// ----------------------------------------------------------------------------
`default_nettype none

package fapl_pkg;

    localparam int TABLE_DEPTH_DEF = 256;

    localparam int CMD_W    = 2;
    localparam int FTYPE_W  = 2;
    localparam int MAC_W    = 48;
    localparam int CHAN_W   = 8;
    localparam int RIDX_W   = 8;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 9;

    localparam logic [CMD_W-1:0] CMD_OBSERVE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

    localparam logic [FTYPE_W-1:0] FT_OTHER = 2'd3;

    typedef enum logic [STATUS_W-1:0] {
        STS_ADDED   = 3'd0,
        STS_PRESENT = 3'd1,
        STS_FULL    = 3'd2,
        STS_IGNORED = 3'd3,
        STS_CLEARED = 3'd4,
        STS_READ_OK = 3'd5,
        STS_RANGE   = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_READ,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [MAC_W-1:0]  src;
        logic [MAC_W-1:0]  dst;
        logic [CHAN_W-1:0] chan;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [FTYPE_W-1:0] ftype;
        t_entry             key;
        logic [RIDX_W-1:0]  read_index;
    } t_item;

    typedef struct packed {
        t_status            status;
        logic [COUNT_W-1:0] count;
        t_entry             entry;
    } t_res;

endpackage

`default_nettype wire

@@ rtl/frame_address_pair_learning_table.sv @@
// ----------------------------------------------------------------------------
// frame_address_pair_learning_table
// learns distinct (source, destination, channel) triples with clear and read
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake          payload
//  input    in         i_valid / o_stall  command, frame type, addresses, channel, read index
//  output   out        o_valid / i_stall  status, entry count, read entry fields
//
//  observe of a valid type on a filled table runs a linear search through the ram read port,
//  one entry a cycle over the filled entries; read, clear, ignored and observe on an empty
//  table do not search
//  reset clears the fill count but not the entry store, which needs no clearing pass
//  one item at a time; a new item is taken while a result waits in the output
//  register, and the finished result waits in the sequencer while i_stall holds
// ----------------------------------------------------------------------------
`default_nettype none

module frame_address_pair_learning_table #(
    parameter int TABLE_DEPTH = fapl_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [fapl_pkg::CMD_W-1:0]     i_command,
    input  wire logic [fapl_pkg::FTYPE_W-1:0]   i_frame_type,
    input  wire logic [fapl_pkg::MAC_W-1:0]     i_source_address,
    input  wire logic [fapl_pkg::MAC_W-1:0]     i_dest_address,
    input  wire logic [fapl_pkg::CHAN_W-1:0]    i_channel,
    input  wire logic [fapl_pkg::RIDX_W-1:0]    i_read_index,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [fapl_pkg::STATUS_W-1:0]       o_status,
    output logic [fapl_pkg::COUNT_W-1:0]        o_entry_count,
    output logic [fapl_pkg::MAC_W-1:0]          o_read_source,
    output logic [fapl_pkg::MAC_W-1:0]          o_read_dest,
    output logic [fapl_pkg::CHAN_W-1:0]         o_read_channel
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    fapl_pkg::t_item  item;
    fapl_pkg::t_res   res;
    fapl_pkg::t_entry wr_data;
    fapl_pkg::t_entry rd_data;
    fapl_pkg::t_res   r_out;

    logic          busy;
    logic          start;
    logic          res_valid;
    logic          take;
    logic          r_out_valid;
    logic          wr_en;
    logic          rd_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    assign item.cmd        = i_command;
    assign item.ftype      = i_frame_type;
    assign item.key.src    = i_source_address;
    assign item.key.dst    = i_dest_address;
    assign item.key.chan   = i_channel;
    assign item.read_index = i_read_index;

    assign o_stall = busy;
    assign start   = i_valid && !busy;
    // output register free or being emptied by this transfer
    assign take    = res_valid && (!r_out_valid || !i_stall);

    fapl_seq #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_item      (item),
        .i_take      (take),
        .o_busy      (busy),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    fapl_ram #(
        .WIDTH (fapl_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out.status;
    assign o_entry_count  = r_out.count;
    assign o_read_source  = r_out.entry.src;
    assign o_read_dest    = r_out.entry.dst;
    assign o_read_channel = r_out.entry.chan;

endmodule

`default_nettype wire

@@ rtl/fapl_ram.sv @@
// ----------------------------------------------------------------------------
// fapl_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module fapl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/fapl_seq.sv @@
// ----------------------------------------------------------------------------
// fapl_seq
// command sequencer with the shared entry compare unit and the fill count
// ----------------------------------------------------------------------------
`default_nettype none

module fapl_seq #(
    parameter int DEPTH = fapl_pkg::TABLE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire fapl_pkg::t_item       i_item,
    input  wire logic                  i_take,
    output logic                       o_busy,
    output logic                       o_res_valid,
    output fapl_pkg::t_res             o_res,
    output logic                       o_wr_en,
    output logic [AW-1:0]              o_wr_addr,
    output fapl_pkg::t_entry           o_wr_data,
    output logic                       o_rd_en,
    output logic [AW-1:0]              o_rd_addr,
    input  wire fapl_pkg::t_entry      i_rd_data
);

    localparam int IW = (CW > fapl_pkg::RIDX_W) ? CW : fapl_pkg::RIDX_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    fapl_pkg::t_state r_state, n_state;
    fapl_pkg::t_entry r_key,   n_key;
    fapl_pkg::t_res   r_res,   n_res;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_scan,  n_scan;
    logic             r_pend,  n_pend;

    logic          issue;
    logic          match;
    logic          in_range;
    logic [IW-1:0] idx_w;
    logic [CW-1:0] count_inc;

    assign issue     = (r_state == fapl_pkg::ST_SEARCH) && (r_scan < r_count);
    assign match     = r_pend && (i_rd_data == r_key);
    assign idx_w     = IW'(i_item.read_index);
    assign in_range  = idx_w < IW'(r_count);
    assign count_inc = r_count + CW'(1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fapl_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = fapl_pkg::ST_FINISH;
                    case (i_item.cmd)
                        fapl_pkg::CMD_OBSERVE: begin
                            if (i_item.ftype != fapl_pkg::FT_OTHER && r_count != '0) begin
                                n_state = fapl_pkg::ST_SEARCH;
                            end
                        end
                        fapl_pkg::CMD_READ: begin
                            if (in_range) begin
                                n_state = fapl_pkg::ST_READ;
                            end
                        end
                        default: n_state = fapl_pkg::ST_FINISH;
                    endcase
                end
            end
            fapl_pkg::ST_SEARCH: begin
                if (match || !issue) begin
                    n_state = fapl_pkg::ST_FINISH;
                end
            end
            fapl_pkg::ST_READ:   n_state = fapl_pkg::ST_FINISH;
            fapl_pkg::ST_FINISH: begin
                if (i_take) begin
                    n_state = fapl_pkg::ST_IDLE;
                end
            end
            default: n_state = fapl_pkg::ST_IDLE;
        endcase
    end

    // datapath and ram control
    always_comb begin
        n_key     = r_key;
        n_res     = r_res;
        n_count   = r_count;
        n_scan    = r_scan;
        n_pend    = 1'b0;
        o_wr_en   = 1'b0;
        o_wr_addr = r_count[AW-1:0];
        o_wr_data = r_key;
        o_rd_en   = 1'b0;
        o_rd_addr = r_scan[AW-1:0];
        case (r_state)
            fapl_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_key        = i_item.key;
                    n_scan       = '0;
                    n_res.entry  = '0;
                    n_res.count  = fapl_pkg::COUNT_W'(r_count);
                    n_res.status = fapl_pkg::STS_IGNORED;
                    case (i_item.cmd)
                        fapl_pkg::CMD_OBSERVE: begin
                            // empty table: append straight away
                            if (i_item.ftype != fapl_pkg::FT_OTHER && r_count == '0) begin
                                o_wr_en      = 1'b1;
                                o_wr_addr    = '0;
                                o_wr_data    = i_item.key;
                                n_count      = CW'(1);
                                n_res.count  = fapl_pkg::COUNT_W'(1);
                                n_res.status = fapl_pkg::STS_ADDED;
                            end
                        end
                        fapl_pkg::CMD_CLEAR: begin
                            n_count      = '0;
                            n_res.count  = '0;
                            n_res.status = fapl_pkg::STS_CLEARED;
                        end
                        fapl_pkg::CMD_READ: begin
                            if (in_range) begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = idx_w[AW-1:0];
                            end else begin
                                n_res.status = fapl_pkg::STS_RANGE;
                            end
                        end
                        default: n_res.status = fapl_pkg::STS_IGNORED;
                    endcase
                end
            end
            fapl_pkg::ST_SEARCH: begin
                // issue one entry a cycle, compare the one read last cycle
                o_rd_en = issue;
                n_pend  = issue;
                if (issue) begin
                    n_scan = r_scan + CW'(1);
                end
                if (match) begin
                    n_res.status = fapl_pkg::STS_PRESENT;
                end else if (!issue) begin
                    if (r_count < DEPTH_C) begin
                        o_wr_en      = 1'b1;
                        n_count      = count_inc;
                        n_res.count  = fapl_pkg::COUNT_W'(count_inc);
                        n_res.status = fapl_pkg::STS_ADDED;
                    end else begin
                        n_res.status = fapl_pkg::STS_FULL;
                    end
                end
            end
            fapl_pkg::ST_READ: begin
                n_res.entry  = i_rd_data;
                n_res.status = fapl_pkg::STS_READ_OK;
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fapl_pkg::ST_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_res  <= n_res;
        r_scan <= n_scan;
    end

    assign o_busy      = (r_state != fapl_pkg::ST_IDLE);
    assign o_res_valid = (r_state == fapl_pkg::ST_FINISH);
    assign o_res       = r_res;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("fill count beyond table depth");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> (r_count < DEPTH_C))
        else $error("append into a full table");

    a_count_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_count != $past(r_count)) |->
            ($past(r_state) == fapl_pkg::ST_IDLE || $past(r_state) == fapl_pkg::ST_SEARCH))
        else $error("fill count changed outside idle or search");

    a_pend_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_pend) |-> $past(o_rd_en && r_state == fapl_pkg::ST_SEARCH))
        else $error("compare without an issued search read");

endmodule

`default_nettype wire
